/* rtl/core/hca_pkg.sv */
package hca_pkg;

    localparam int SYM_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 3;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_SYMBOLS,
        PH_LENGTHS,
        PH_NAME,
        PH_DATA,
        PH_HALT
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_NAME_CHAR   = 3'd0,
        EV_DATA_BYTE   = 3'd1,
        EV_NAME_END    = 3'd2,
        EV_FILE_END    = 3'd3,
        EV_ARCHIVE_END = 3'd4,
        EV_ERROR       = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        CFG_NAME_END    = 2'd0,
        CFG_NEXT_FILE   = 2'd1,
        CFG_ARCHIVE_END = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_event             ev;
        logic [BYTE_W-1:0]  byte_val;
    } t_result;

endpackage

/* rtl/core/hca_in_if.sv */
interface hca_in_if;
    logic valid;
    logic ready;
    logic stream_bit;

    modport source (output valid, output stream_bit, input ready);
    modport sink   (input valid, input stream_bit, output ready);
endinterface

/* rtl/core/hca_out_if.sv */
interface hca_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] byte_value;

    modport source (output valid, output event_res, output byte_value, input ready);
    modport sink   (input valid, input event_res, input byte_value, output ready);
endinterface

/* rtl/core/hca_sym_mem.sv */
module hca_sym_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [hca_pkg::SYM_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [hca_pkg::SYM_W-1:0] o_rdata
);
    import hca_pkg::*;

    logic [SYM_W-1:0] r_mem [DEPTH];
    logic [SYM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/hca_out_fifo.sv */
module hca_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hca_pkg::t_result   i_push_data,
    output logic [1:0]         o_count,
    hca_out_if.source          o_out
);
    import hca_pkg::*;

    t_result    r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       pop;

    assign pop = o_out.valid & o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_data;
        end
    end

    assign o_out.valid      = (r_count != 2'd0);
    assign o_out.event_res  = r_slot[r_rd].ev;
    assign o_out.byte_value = r_slot[r_rd].byte_val;
    assign o_count          = r_count;
endmodule

/* rtl/core/canonical_huffman_archive_decoder.sv */
// Channel  Dir  Beat payload            Accepted when
// i_in     in   stream_bit              valid & ready
// o_out    out  event_res, byte_value   valid & ready
//
// Archive bits are taken whenever the input is ready. A bit that completes a code
// stalls the input while the symbol memory read is done, before the next bit is taken.
// Results wait in a two-beat output queue; input stalls when it is full or a lookup is pending.
// Synchronous active-low reset; the symbol memory needs no clearing.
module canonical_huffman_archive_decoder #(
    parameter int MAX_CODE_LEN = 16,
    parameter int SYMBOL_DEPTH = 512
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [hca_pkg::SYM_W-1:0] i_cfg_data,
    hca_in_if.sink                    i_in,
    hca_out_if.source                 o_out
);
    import hca_pkg::*;

    localparam int AW = $clog2(SYMBOL_DEPTH);
    localparam int LW = $clog2(MAX_CODE_LEN + 2);
    localparam int TW = $clog2(MAX_CODE_LEN);
    localparam int FW = MAX_CODE_LEN + 1;
    localparam logic [FW-1:0] FC_SAT = FW'(1) << MAX_CODE_LEN;

    logic [SYM_W-1:0] r_name_end, r_next_file, r_arch_end;

    t_phase              r_phase, n_phase;
    logic [SYM_W-1:0]    r_fshift, n_fshift;
    logic [3:0]          r_fbits, n_fbits;
    logic [SYM_W-1:0]    r_total, n_total;
    logic [SYM_W-1:0]    r_placed, n_placed;
    logic [LW-1:0]       r_longest, n_longest;
    logic [FW-1:0]       r_ncc, n_ncc;
    logic [MAX_CODE_LEN-1:0] r_acc, n_acc;
    logic [LW-1:0]       r_clen, n_clen;
    logic                r_pend, n_pend;
    logic                r_inrange, n_inrange;

    logic [SYM_W-1:0]    r_lcount [MAX_CODE_LEN];
    logic [FW-1:0]       r_fcode  [MAX_CODE_LEN];
    logic [SYM_W-1:0]    r_base   [MAX_CODE_LEN];

    logic                tab_we;
    logic [TW-1:0]       tab_idx;
    logic [SYM_W-1:0]    tab_cnt;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [SYM_W-1:0]    mem_rdata;

    logic                push;
    t_result             push_data;
    logic [1:0]          q_count;
    logic                accept;

    logic [SYM_W-1:0]    fv, rem, cval, sym;
    logic [SYM_W:0]      placed_inc, placed_sum, idx;
    logic [LW-1:0]       len, nlen;
    logic [FW+1:0]       ncc_shift;
    logic [MAX_CODE_LEN-1:0] acc;
    logic [TW-1:0]       dix;
    logic [FW-1:0]       acc_x, diff;
    logic                hit;

    assign i_in.ready = !r_pend && (q_count != 2'd2);
    assign accept     = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_end  <= 9'd256;
            r_next_file <= 9'd257;
            r_arch_end  <= 9'd258;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NAME_END:    r_name_end  <= i_cfg_data;
                CFG_NEXT_FILE:   r_next_file <= i_cfg_data;
                CFG_ARCHIVE_END: r_arch_end  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_COUNT;
            r_fshift  <= '0;
            r_fbits   <= '0;
            r_total   <= '0;
            r_placed  <= '0;
            r_longest <= '0;
            r_ncc     <= '0;
            r_acc     <= '0;
            r_clen    <= '0;
            r_pend    <= 1'b0;
            r_inrange <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_fshift  <= n_fshift;
            r_fbits   <= n_fbits;
            r_total   <= n_total;
            r_placed  <= n_placed;
            r_longest <= n_longest;
            r_ncc     <= n_ncc;
            r_acc     <= n_acc;
            r_clen    <= n_clen;
            r_pend    <= n_pend;
            r_inrange <= n_inrange;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_lcount[tab_idx] <= tab_cnt;
            r_fcode[tab_idx]  <= r_ncc;
            r_base[tab_idx]   <= r_placed;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_fshift  = r_fshift;
        n_fbits   = r_fbits;
        n_total   = r_total;
        n_placed  = r_placed;
        n_longest = r_longest;
        n_ncc     = r_ncc;
        n_acc     = r_acc;
        n_clen    = r_clen;
        n_pend    = 1'b0;
        n_inrange = r_inrange;
        tab_we    = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        push      = 1'b0;
        push_data = '{ev: EV_ERROR, byte_val: '0};

        fv         = {r_fshift[SYM_W-2:0], i_in.stream_bit};
        rem        = r_total - r_placed;
        cval       = (fv > rem) ? rem : fv;
        len        = r_longest + LW'(1);
        tab_idx    = TW'(len - LW'(1));
        tab_cnt    = cval;
        placed_inc = {1'b0, r_placed} + 10'd1;
        placed_sum = {1'b0, r_placed} + {1'b0, cval};
        ncc_shift  = {({1'b0, r_ncc} + (FW+1)'(cval)), 1'b0};
        mem_waddr  = r_placed[AW-1:0];

        acc   = {r_acc[MAX_CODE_LEN-2:0], i_in.stream_bit};
        nlen  = r_clen + LW'(1);
        dix   = TW'(nlen - LW'(1));
        acc_x = {1'b0, acc};
        diff  = acc_x - r_fcode[dix];
        hit   = (r_lcount[dix] != '0) && (acc_x >= r_fcode[dix]) &&
                (diff < FW'(r_lcount[dix]));
        idx       = {1'b0, r_base[dix]} + {1'b0, diff[SYM_W-1:0]};
        mem_raddr = idx[AW-1:0];
        sym       = r_inrange ? mem_rdata : '0;

        if (r_pend) begin
            push = 1'b1;
            if (r_phase == PH_NAME) begin
                if (sym == r_name_end) begin
                    n_phase   = PH_DATA;
                    push_data = '{ev: EV_NAME_END, byte_val: '0};
                end else begin
                    push_data = '{ev: EV_NAME_CHAR, byte_val: sym[BYTE_W-1:0]};
                end
            end else if (sym == r_next_file) begin
                n_phase   = PH_COUNT;
                n_fshift  = '0;
                n_fbits   = '0;
                n_total   = '0;
                n_placed  = '0;
                n_longest = '0;
                n_ncc     = '0;
                push_data = '{ev: EV_FILE_END, byte_val: '0};
            end else if (sym == r_arch_end) begin
                n_phase   = PH_HALT;
                push_data = '{ev: EV_ARCHIVE_END, byte_val: '0};
            end else begin
                push_data = '{ev: EV_DATA_BYTE, byte_val: sym[BYTE_W-1:0]};
            end
        end else if (accept) begin
            unique case (r_phase)
                PH_COUNT, PH_SYMBOLS, PH_LENGTHS: begin
                    if (r_fbits != 4'(SYM_W - 1)) begin
                        n_fshift = fv;
                        n_fbits  = r_fbits + 4'd1;
                    end else begin
                        n_fshift = '0;
                        n_fbits  = '0;
                        if (r_phase == PH_COUNT) begin
                            n_total  = fv;
                            n_placed = '0;
                            if (fv == '0) begin
                                n_longest = '0;
                                n_acc     = '0;
                                n_clen    = '0;
                                n_phase   = PH_NAME;
                            end else begin
                                n_phase = PH_SYMBOLS;
                            end
                        end else if (r_phase == PH_SYMBOLS) begin
                            mem_we   = ({1'b0, r_placed} < 10'(SYMBOL_DEPTH));
                            n_placed = placed_inc[SYM_W-1:0];
                            if (placed_inc >= {1'b0, r_total}) begin
                                n_placed  = '0;
                                n_longest = '0;
                                n_ncc     = '0;
                                n_phase   = PH_LENGTHS;
                            end
                        end else if (len > LW'(MAX_CODE_LEN)) begin
                            n_phase = PH_HALT;
                            push    = 1'b1;
                        end else begin
                            tab_we    = 1'b1;
                            n_placed  = placed_sum[SYM_W-1:0];
                            n_longest = len;
                            if (ncc_shift[FW+1:MAX_CODE_LEN] != '0) begin
                                n_ncc = FC_SAT;
                            end else begin
                                n_ncc = ncc_shift[FW-1:0];
                            end
                            if (placed_sum >= {1'b0, r_total}) begin
                                n_acc   = '0;
                                n_clen  = '0;
                                n_phase = PH_NAME;
                            end else if (len >= LW'(MAX_CODE_LEN)) begin
                                n_phase = PH_HALT;
                                push    = 1'b1;
                            end
                        end
                    end
                end
                PH_NAME, PH_DATA: begin
                    if (nlen > r_longest) begin
                        n_phase = PH_HALT;
                        push    = 1'b1;
                    end else if (hit) begin
                        n_acc     = '0;
                        n_clen    = '0;
                        n_pend    = 1'b1;
                        mem_re    = 1'b1;
                        n_inrange = (idx < 10'(SYMBOL_DEPTH));
                    end else if (nlen >= r_longest) begin
                        n_phase = PH_HALT;
                        push    = 1'b1;
                    end else begin
                        n_acc  = acc;
                        n_clen = nlen;
                    end
                end
                PH_HALT: begin
                end
                default: begin
                end
            endcase
        end
    end

    hca_sym_mem #(
        .DEPTH (SYMBOL_DEPTH),
        .AW    (AW)
    ) u_sym_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (fv),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hca_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_count     (q_count),
        .o_out       (o_out)
    );

`ifndef ASSERT_OFF
    a_pend_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !i_in.ready)
        else $error("input taken during symbol lookup");
    a_pend_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> !r_pend)
        else $error("lookup lasted more than one cycle");
    a_halt_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALT) |=> (r_phase == PH_HALT))
        else $error("left halt without reset");
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_count != 2'd2) || (o_out.valid && o_out.ready))
        else $error("result pushed into full queue");
`endif
endmodule
